// ===== rtl/pvo_pkg.sv =====
// Shared types, register map and helpers for the pixel visit order generator.
package pvo_pkg;

    localparam int PIX_W           = 12;
    localparam int DIM_CFG_W       = 13;
    localparam int GROUP_CFG_W     = 16;
    localparam int MODE_W          = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int HIL_GROUP_SHIFT = 8;

    localparam int RESET_FRAME_DIM = 256;
    localparam int RESET_TILE_DIM  = 32;
    localparam int RESET_GROUP     = 256;

    localparam logic [CFG_ADDR_W-1:0] REG_ORDER_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SCAN_GROUP_SIZE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_WIDTH      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_HEIGHT     = 3'd5;

    localparam logic [MODE_W-1:0] ORDER_SCAN  = 2'd0;
    localparam logic [MODE_W-1:0] ORDER_CURVE = 2'd1;
    localparam logic [MODE_W-1:0] ORDER_TILE  = 2'd2;

    // direct position, or a curve index still to be converted
    typedef enum logic {
        CMD_POS   = 1'b0,
        CMD_CURVE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic in_picture;
        logic group_last;
        logic frame_last;
    } cmd_flags_t;

    function automatic logic [DIM_CFG_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v,
                                                       input logic [DIM_CFG_W-1:0] max_v);
        logic [DIM_CFG_W-1:0] r;
        if (v == '0) begin
            r = DIM_CFG_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pvo_fifo.sv =====
// Small command queue between the walk sequencer and the conversion pipeline.
module pvo_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/pvo_front.sv =====
// Walk sequencer: keeps the frame walk state and turns each step into a command.
module pvo_front #(
    parameter int CW  = 12,
    parameter int DW  = 13,
    parameter int GW  = 17,
    parameter int LVW = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_accept,
    input  logic                            restart,
    input  logic                            walk_clear,
    input  logic [pvo_pkg::MODE_W-1:0]      order_mode,
    input  logic [DW-1:0]                   frame_w,
    input  logic [DW-1:0]                   frame_h,
    input  logic [DW-1:0]                   tile_w,
    input  logic [DW-1:0]                   tile_h,
    input  logic [pvo_pkg::GROUP_CFG_W-1:0] scan_group,
    input  logic [GW-1:0]                   curve_group,
    input  logic [LVW-1:0]                  curve_levels,
    output pvo_pkg::cmd_kind_t              cmd_kind,
    output pvo_pkg::cmd_flags_t             cmd_flags,
    output logic [2*CW-1:0]                 cmd_data
);
    import pvo_pkg::*;

    logic [CW-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [CW-1:0]   tox_reg, tox_next, toy_reg, toy_next;
    logic [2*CW-1:0] idx_reg, idx_next;
    logic [GW-1:0]   gc_reg, gc_next;
    logic            done_reg, done_next;

    logic [CW-1:0]   cx, cy, tox, toy, pos_x, pos_y;
    logic [2*CW-1:0] idx, last_mask;
    logic [GW-1:0]   gc, group_target;
    logic            done;
    logic [CW:0]     cx_inc, cy_inc;
    logic [GW:0]     gc_inc;
    logic            group_hit, last, tile_none;
    logic [CW+1:0]   tox_new, toy_new;

    always_comb begin
        // a restart item sees a freshly cleared walk
        cx   = restart ? '0 : cx_reg;
        cy   = restart ? '0 : cy_reg;
        tox  = restart ? '0 : tox_reg;
        toy  = restart ? '0 : toy_reg;
        idx  = restart ? '0 : idx_reg;
        gc   = restart ? '0 : gc_reg;
        done = restart ? 1'b0 : done_reg;

        for (int j = 0; j < 2*CW; j++) begin
            last_mask[j] = (j < 2*int'(curve_levels));
        end

        group_target = (order_mode == ORDER_CURVE) ? curve_group :
                       (scan_group == '0) ? GW'(1) : GW'(scan_group);
        cx_inc    = (CW+1)'(cx) + 1'b1;
        cy_inc    = (CW+1)'(cy) + 1'b1;
        gc_inc    = (GW+1)'(gc) + 1'b1;
        group_hit = (gc_inc >= (GW+1)'(group_target));
        tile_none = (tile_w > frame_w) || (tile_h > frame_h);
        tox_new   = (CW+2)'(tox) + (CW+2)'(tile_w);
        toy_new   = (CW+2)'(toy) + (CW+2)'(tile_h);
        pos_x     = tox + cx;
        pos_y     = toy + cy;
        last      = 1'b0;

        cx_next   = cx;
        cy_next   = cy;
        tox_next  = tox;
        toy_next  = toy;
        idx_next  = idx;
        gc_next   = gc;
        done_next = done;

        // idle result unless a live position is produced
        cmd_kind  = CMD_POS;
        cmd_data  = '0;
        cmd_flags = '{in_picture: 1'b0, group_last: 1'b0, frame_last: 1'b1};

        if (!done) begin
            case (order_mode)
                ORDER_CURVE: begin
                    last      = (idx == last_mask);
                    cmd_kind  = CMD_CURVE;
                    cmd_data  = idx;
                    cmd_flags = '{in_picture: 1'b0, group_last: last || group_hit,
                                  frame_last: last};
                    gc_next   = (last || group_hit) ? '0 : GW'(gc_inc);
                    done_next = last;
                    if (!last) begin
                        idx_next = idx + 1'b1;
                    end
                end
                ORDER_TILE: begin
                    if (tile_none) begin
                        done_next = 1'b1;
                    end else begin
                        cmd_data  = {pos_y, pos_x};
                        cmd_flags = '{in_picture: 1'b1, group_last: 1'b0, frame_last: 1'b0};
                        if (cx_inc >= (CW+1)'(tile_w)) begin
                            cx_next = '0;
                            if (cy_inc >= (CW+1)'(tile_h)) begin
                                cy_next = '0;
                                cmd_flags.group_last = 1'b1;
                                if (tox_new + (CW+2)'(tile_w) > (CW+2)'(frame_w)) begin
                                    tox_next = '0;
                                    toy_next = CW'(toy_new);
                                    if (toy_new + (CW+2)'(tile_h) > (CW+2)'(frame_h)) begin
                                        cmd_flags.frame_last = 1'b1;
                                        done_next = 1'b1;
                                    end
                                end else begin
                                    tox_next = CW'(tox_new);
                                end
                            end else begin
                                cy_next = CW'(cy_inc);
                            end
                        end else begin
                            cx_next = CW'(cx_inc);
                        end
                    end
                end
                default: begin
                    last = (cx_inc >= (CW+1)'(frame_w)) && (cy_inc >= (CW+1)'(frame_h));
                    cmd_data  = {cy, cx};
                    cmd_flags = '{in_picture: 1'b1, group_last: last || group_hit,
                                  frame_last: last};
                    gc_next   = (last || group_hit) ? '0 : GW'(gc_inc);
                    done_next = last;
                    if (!last) begin
                        if (cx_inc >= (CW+1)'(frame_w)) begin
                            cx_next = '0;
                            cy_next = CW'(cy_inc);
                        end else begin
                            cx_next = CW'(cx_inc);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || walk_clear) begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            tox_reg  <= '0;
            toy_reg  <= '0;
            idx_reg  <= '0;
            gc_reg   <= '0;
            done_reg <= 1'b0;
        end else if (item_accept) begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            tox_reg  <= tox_next;
            toy_reg  <= toy_next;
            idx_reg  <= idx_next;
            gc_reg   <= gc_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== rtl/pvo_back.sv =====
// Curve index to coordinate pipeline, one curve level per stage, and output register.
module pvo_back #(
    parameter int CW  = 12,
    parameter int DW  = 13,
    parameter int LVW = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_pop,
    input  pvo_pkg::cmd_kind_t  in_kind,
    input  pvo_pkg::cmd_flags_t in_flags,
    input  logic [2*CW-1:0]     in_data,
    input  logic [DW-1:0]       frame_w,
    input  logic [DW-1:0]       frame_h,
    input  logic [LVW-1:0]      curve_levels,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // pixel_x[11:0], pixel_y[23:12]
    output logic                m_tlast,   // group_last
    output logic [1:0]          m_tuser    // in_picture[0], frame_last[1]
);
    import pvo_pkg::*;

    typedef struct packed {
        cmd_kind_t       kind;
        cmd_flags_t      flags;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [2*CW-1:0] idx;
    } stage_t;

    function automatic stage_t apply_level(input stage_t s, input int k,
                                           input logic [LVW-1:0] lv);
        stage_t        r;
        logic          rx, ry;
        logic [CW-1:0] low_mask, xs, ys;
        r        = s;
        rx       = s.idx[2*k+1];
        ry       = s.idx[2*k] ^ rx;
        low_mask = CW'((1 << k) - 1);
        xs       = s.x;
        ys       = s.y;
        if (s.kind == CMD_CURVE && k < int'(lv)) begin
            // rotate the quadrant, then place it
            if (!ry) begin
                if (rx) begin
                    xs = xs ^ low_mask;
                    ys = ys ^ low_mask;
                end
                r.x = ys;
                r.y = xs;
            end else begin
                r.x = xs;
                r.y = ys;
            end
            r.x = r.x | (CW'(rx) << k);
            r.y = r.y | (CW'(ry) << k);
        end
        return r;
    endfunction

    stage_t       st_reg [CW+1];
    logic [CW:0]  valid_reg;
    logic         out_valid_reg;
    logic [23:0]  out_data_reg;
    logic         out_last_reg;
    logic [1:0]   out_user_reg;
    logic         adv;
    stage_t       load;
    stage_t       tail;
    logic         tail_inpic;

    assign adv    = !out_valid_reg || m_tready;
    assign in_pop = adv && in_valid;

    always_comb begin
        load.kind  = in_kind;
        load.flags = in_flags;
        if (in_kind == CMD_CURVE) begin
            load.x   = '0;
            load.y   = '0;
            load.idx = in_data;
        end else begin
            load.x   = in_data[CW-1:0];
            load.y   = in_data[2*CW-1:CW];
            load.idx = '0;
        end
        tail       = st_reg[CW];
        tail_inpic = (tail.kind == CMD_CURVE) ?
                     ((DW'(tail.x) < frame_w) && (DW'(tail.y) < frame_h)) :
                     tail.flags.in_picture;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg     <= {valid_reg[CW-1:0], in_valid};
            out_valid_reg <= valid_reg[CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= load;
            for (int k = 0; k < CW; k++) begin
                st_reg[k+1] <= apply_level(st_reg[k], k, curve_levels);
            end
            out_data_reg <= {PIX_W'(tail.y), PIX_W'(tail.x)};
            out_last_reg <= tail.flags.group_last;
            out_user_reg <= {tail.flags.frame_last, tail_inpic};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/pixel_visit_order_generator.sv =====
// Top level: configuration registers, walk sequencer, command queue and conversion pipeline.
//
// Every item on the input stream (s_tdata[0] = restart) produces exactly one pixel position
// on the output stream, in scanline, Hilbert-curve or whole-tile order as set by order_mode.
// One item is accepted per clock cycle for as long as the output side keeps taking results;
// each result passes through the four-entry command queue, a load stage, one pipeline stage
// per curve level (CW levels, where CW = ceil(log2(MAX_DIM)) capped at 13) and one output
// register, the same path in every mode. The walk state is advanced by the sequencer in the
// accepting cycle, so a restart item already yields the first position of the frame. Any write
// to addresses 0 to 5 restarts the walk; registers may be written only while no results are
// outstanding.
module pixel_visit_order_generator #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,    // restart[0], zero fill above
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,    // pixel_x[11:0], pixel_y[23:12]
    output logic                           m_tlast,    // group_last
    output logic [1:0]                     m_tuser,    // in_picture[0], frame_last[1]
    input  logic                           cfg_we,
    input  logic [pvo_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pvo_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pvo_pkg::*;

    localparam int DIM_LIMIT  = (1 << DIM_CFG_W) - 1;
    localparam int EFF_MAX    = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
    localparam int CW         = $clog2(EFF_MAX);
    localparam int DW         = $clog2(EFF_MAX + 1);
    localparam int LVW        = $clog2(CW + 1);
    localparam int GW_RAW     = $clog2(((EFF_MAX * EFF_MAX) >> HIL_GROUP_SHIFT) + 1);
    localparam int GW         = (GW_RAW > GROUP_CFG_W) ? GW_RAW : GROUP_CFG_W;
    localparam int RST_DIM    = (EFF_MAX < RESET_FRAME_DIM) ? EFF_MAX : RESET_FRAME_DIM;
    localparam int RST_GS_RAW = (RST_DIM * RST_DIM) >> HIL_GROUP_SHIFT;
    localparam int RST_GS     = (RST_GS_RAW < 1) ? 1 : RST_GS_RAW;
    localparam int FIFO_DEPTH = 4;
    localparam int CMD_W      = 1 + $bits(cmd_flags_t) + 2*CW;

    logic [MODE_W-1:0]      order_mode_reg;
    logic [DIM_CFG_W-1:0]   frame_width_reg, frame_height_reg;
    logic [GROUP_CFG_W-1:0] scan_group_size_reg;
    logic [DIM_CFG_W-1:0]   tile_width_reg, tile_height_reg;
    logic [GW-1:0]          curve_group_reg, curve_group_next;

    logic [DW-1:0]     frame_w_cl, frame_h_cl, tile_w_cl, tile_h_cl;
    logic [DW-1:0]     wdata_cl, mul_a, mul_b, span, span_m1;
    logic [2*DW-1:0]   area;
    logic [GW-1:0]     area_q;
    logic [LVW-1:0]    curve_levels;
    logic              walk_clear, dims_write, item_accept;

    cmd_kind_t         cmd_kind;
    cmd_flags_t        cmd_flags;
    logic [2*CW-1:0]   cmd_data;
    logic [CMD_W-1:0]  q_wr, q_rd;
    logic              q_full, q_empty, q_pop;

    assign walk_clear  = cfg_we && (cfg_addr <= REG_TILE_HEIGHT);
    assign dims_write  = cfg_we && (cfg_addr == REG_FRAME_WIDTH || cfg_addr == REG_FRAME_HEIGHT);
    assign s_tready    = !q_full;
    assign item_accept = s_tvalid && s_tready;

    assign frame_w_cl = DW'(clamp_dim(frame_width_reg, DIM_CFG_W'(EFF_MAX)));
    assign frame_h_cl = DW'(clamp_dim(frame_height_reg, DIM_CFG_W'(EFF_MAX)));
    assign tile_w_cl  = DW'(clamp_dim(tile_width_reg, DIM_CFG_W'(EFF_MAX)));
    assign tile_h_cl  = DW'(clamp_dim(tile_height_reg, DIM_CFG_W'(EFF_MAX)));

    // curve side n = 2^levels, the power of two at or above the larger side
    always_comb begin
        span         = (frame_w_cl > frame_h_cl) ? frame_w_cl : frame_h_cl;
        span_m1      = span - 1'b1;
        curve_levels = '0;
        for (int j = 0; j < CW; j++) begin
            if (span_m1[j]) begin
                curve_levels = LVW'(j + 1);
            end
        end
    end

    // curve group size follows w*h, recomputed from the value being written
    always_comb begin
        wdata_cl = DW'(clamp_dim(cfg_wdata[DIM_CFG_W-1:0], DIM_CFG_W'(EFF_MAX)));
        mul_a    = (cfg_addr == REG_FRAME_WIDTH) ? wdata_cl : frame_w_cl;
        mul_b    = (cfg_addr == REG_FRAME_HEIGHT) ? wdata_cl : frame_h_cl;
        area     = mul_a * mul_b;
        area_q   = GW'(area >> HIL_GROUP_SHIFT);
        curve_group_next = (area_q == '0) ? GW'(1) : area_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg      <= ORDER_SCAN;
            frame_width_reg     <= DIM_CFG_W'(RESET_FRAME_DIM);
            frame_height_reg    <= DIM_CFG_W'(RESET_FRAME_DIM);
            scan_group_size_reg <= GROUP_CFG_W'(RESET_GROUP);
            tile_width_reg      <= DIM_CFG_W'(RESET_TILE_DIM);
            tile_height_reg     <= DIM_CFG_W'(RESET_TILE_DIM);
            curve_group_reg     <= GW'(RST_GS);
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ORDER_MODE:      order_mode_reg      <= cfg_wdata[MODE_W-1:0];
                    REG_FRAME_WIDTH:     frame_width_reg     <= cfg_wdata[DIM_CFG_W-1:0];
                    REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_wdata[DIM_CFG_W-1:0];
                    REG_SCAN_GROUP_SIZE: scan_group_size_reg <= cfg_wdata[GROUP_CFG_W-1:0];
                    REG_TILE_WIDTH:      tile_width_reg      <= cfg_wdata[DIM_CFG_W-1:0];
                    REG_TILE_HEIGHT:     tile_height_reg     <= cfg_wdata[DIM_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (dims_write) begin
                curve_group_reg <= curve_group_next;
            end
        end
    end

    pvo_front #(
        .CW  (CW),
        .DW  (DW),
        .GW  (GW),
        .LVW (LVW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_accept  (item_accept),
        .restart      (s_tdata[0]),
        .walk_clear   (walk_clear),
        .order_mode   (order_mode_reg),
        .frame_w      (frame_w_cl),
        .frame_h      (frame_h_cl),
        .tile_w       (tile_w_cl),
        .tile_h       (tile_h_cl),
        .scan_group   (scan_group_size_reg),
        .curve_group  (curve_group_reg),
        .curve_levels (curve_levels),
        .cmd_kind     (cmd_kind),
        .cmd_flags    (cmd_flags),
        .cmd_data     (cmd_data)
    );

    assign q_wr = {cmd_kind, cmd_flags, cmd_data};

    pvo_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (item_accept),
        .wr_data (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    pvo_back #(
        .CW  (CW),
        .DW  (DW),
        .LVW (LVW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (!q_empty),
        .in_pop       (q_pop),
        .in_kind      (cmd_kind_t'(q_rd[CMD_W-1])),
        .in_flags     (cmd_flags_t'(q_rd[CMD_W-2:2*CW])),
        .in_data      (q_rd[2*CW-1:0]),
        .frame_w      (frame_w_cl),
        .frame_h      (frame_h_cl),
        .curve_levels (curve_levels),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

// ===== tb/tb_pixel_visit_order_generator.sv =====
// Self-checking testbench for the pixel visit order generator: scanline, curve and tile walks.
module tb_pixel_visit_order_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import pvo_pkg::*;

    localparam int SIDE_MAX   = 4096;
    localparam int PIPE_DEPTH = 14;
    localparam int PRINT_CAP  = 100;

    // unused mode code, walks as scanline
    localparam logic [MODE_W-1:0] ORDER_SPARE = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             in_picture;
        logic             group_last;
        logic             frame_last;
    } visit_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;     // restart[0], zero fill above
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;            // pixel_x[11:0], pixel_y[23:12]
    logic                  m_tlast;            // group_last
    logic [1:0]            m_tuser;            // in_picture[0], frame_last[1]
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    pixel_visit_order_generator #(.MAX_DIM(SIDE_MAX)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // predictor copy of the registers and the walk state
    logic [MODE_W-1:0]      set_mode  = ORDER_SCAN;
    logic [DIM_CFG_W-1:0]   set_w     = DIM_CFG_W'(RESET_FRAME_DIM);
    logic [DIM_CFG_W-1:0]   set_h     = DIM_CFG_W'(RESET_FRAME_DIM);
    logic [GROUP_CFG_W-1:0] set_group = GROUP_CFG_W'(RESET_GROUP);
    logic [DIM_CFG_W-1:0]   set_tw    = DIM_CFG_W'(RESET_TILE_DIM);
    logic [DIM_CFG_W-1:0]   set_th    = DIM_CFG_W'(RESET_TILE_DIM);
    int unsigned cur_x = 0, cur_y = 0, org_x = 0, org_y = 0, curve_idx = 0, grp_cnt = 0;
    bit          walk_done = 1'b0;

    bit     pending_restart[$];
    visit_t visit_q[$];

    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int sink_stall_cycles = 0;
    int items_sent        = 0;
    int results_seen      = 0;
    int errors            = 0;
    int settings_done     = 0;

    function automatic void clear_walk();
        cur_x = 0; cur_y = 0;
        org_x = 0; org_y = 0;
        curve_idx = 0; grp_cnt = 0;
        walk_done = 1'b0;
    endfunction

    function automatic int unsigned clamp_side(input int unsigned v);
        if (v == 0) return 1;
        if (v > SIDE_MAX) return SIDE_MAX;
        return v;
    endfunction

    // Hilbert index to (x, y), one quadrant level per pass
    function automatic void curve_xy(input int unsigned n, input int unsigned idx,
                                     output int unsigned cx, output int unsigned cy);
        int unsigned t, s, rx, ry, tmp;
        cx = 0;
        cy = 0;
        t  = idx;
        for (s = 1; s < n; s = s << 1) begin
            rx = (t >> 1) & 1;
            ry = (t ^ rx) & 1;
            if (ry == 0) begin
                if (rx == 1) begin
                    cx = s - 1 - cx;
                    cy = s - 1 - cy;
                end
                tmp = cx;
                cx  = cy;
                cy  = tmp;
            end
            cx += s * rx;
            cy += s * ry;
            t = t >> 2;
        end
    endfunction

    // next visited position for one accepted item
    function automatic visit_t walk_step(input bit restart);
        int unsigned w, h, side, n, gsize, tw, th, g, px, py;
        bit          inpic, glast, flast;
        visit_t      v;
        w = clamp_side(set_w);
        h = clamp_side(set_h);
        px = 0; py = 0;
        inpic = 1'b0; glast = 1'b0; flast = 1'b1;
        if (restart) clear_walk();
        if (!walk_done) begin
            if (set_mode == ORDER_CURVE) begin
                side = (w > h) ? w : h;
                n = 1;
                while (n < side) n = n << 1;
                gsize = (w * h) >> HIL_GROUP_SHIFT;
                if (gsize < 1) gsize = 1;
                curve_xy(n, curve_idx, px, py);
                inpic = (px < w) && (py < h);
                flast = curve_idx >= n * n - 1;
                glast = flast || (grp_cnt + 1 >= gsize);
                grp_cnt = glast ? 0 : grp_cnt + 1;
                if (flast) walk_done = 1'b1;
                else curve_idx++;
            end else if (set_mode == ORDER_TILE) begin
                tw = clamp_side(set_tw);
                th = clamp_side(set_th);
                if (w / tw == 0 || h / th == 0) begin
                    walk_done = 1'b1;
                end else begin
                    px = org_x + cur_x;
                    py = org_y + cur_y;
                    inpic = 1'b1;
                    flast = 1'b0;
                    cur_x++;
                    if (cur_x >= tw) begin
                        cur_x = 0;
                        cur_y++;
                        if (cur_y >= th) begin
                            cur_y = 0;
                            glast = 1'b1;
                            org_x += tw;
                            if (org_x + tw > w) begin
                                org_x = 0;
                                org_y += th;
                                if (org_y + th > h) begin
                                    flast = 1'b1;
                                    walk_done = 1'b1;
                                end
                            end
                        end
                    end
                end
            end else begin
                g = (set_group == 0) ? 1 : set_group;
                px = cur_x;
                py = cur_y;
                inpic = 1'b1;
                flast = (cur_x + 1 >= w) && (cur_y + 1 >= h);
                glast = flast || (grp_cnt + 1 >= g);
                grp_cnt = glast ? 0 : grp_cnt + 1;
                if (flast) begin
                    walk_done = 1'b1;
                end else begin
                    cur_x++;
                    if (cur_x >= w) begin
                        cur_x = 0;
                        cur_y++;
                    end
                end
            end
        end
        if (!inpic && walk_done && flast && !glast) begin
            px = 0;
            py = 0;
        end
        v.x          = PIX_W'(px);
        v.y          = PIX_W'(py);
        v.in_picture = inpic;
        v.group_last = glast;
        v.frame_last = flast;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t ns: mismatch on %s at result %0d: got %0h, want %0h",
                     $time, what, results_seen, got, want);
    endtask

    // driver: one pending item per handshake, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                visit_q.push_back(walk_step(s_tdata[0]));
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_restart.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= {7'd0, pending_restart.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest predicted position
    always @(posedge aclk) begin
        visit_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (visit_q.size() == 0) begin
                    report_mismatch("item with nothing pending", 32'(m_tdata), 32'd0);
                end else begin
                    want = visit_q.pop_front();
                    if (m_tdata[PIX_W-1:0] !== want.x)
                        report_mismatch("pixel_x", 32'(m_tdata[PIX_W-1:0]), 32'(want.x));
                    if (m_tdata[2*PIX_W-1:PIX_W] !== want.y)
                        report_mismatch("pixel_y", 32'(m_tdata[2*PIX_W-1:PIX_W]),
                                        32'(want.y));
                    if (m_tuser[0] !== want.in_picture)
                        report_mismatch("in_picture", 32'(m_tuser[0]), 32'(want.in_picture));
                    if (m_tlast !== want.group_last)
                        report_mismatch("group_last", 32'(m_tlast), 32'(want.group_last));
                    if (m_tuser[1] !== want.frame_last)
                        report_mismatch("frame_last", 32'(m_tuser[1]), 32'(want.frame_last));
                end
            end
            if (sink_stall_cycles > 0) begin
                m_tready <= 1'b0;
                sink_stall_cycles--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (addr)
            REG_ORDER_MODE:      set_mode  = data[MODE_W-1:0];
            REG_FRAME_WIDTH:     set_w     = data[DIM_CFG_W-1:0];
            REG_FRAME_HEIGHT:    set_h     = data[DIM_CFG_W-1:0];
            REG_SCAN_GROUP_SIZE: set_group = data[GROUP_CFG_W-1:0];
            REG_TILE_WIDTH:      set_tw    = data[DIM_CFG_W-1:0];
            REG_TILE_HEIGHT:     set_th    = data[DIM_CFG_W-1:0];
            default: ;
        endcase
        clear_walk();
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_restart.size() != 0 || s_tvalid || visit_q.size() != 0);
    endtask

    // restart flags, lowest bit first
    task automatic queue_bits(input logic [31:0] bits, input int n);
        for (int i = 0; i < n; i++) pending_restart.push_back(bits[i]);
    endtask

    task automatic queue_items(input int n, input int restart_pct);
        for (int i = 0; i < n; i++)
            pending_restart.push_back($urandom_range(0, 99) < restart_pct);
    endtask

    // side length: mostly small, sometimes zero or past the limit, junk above bit 12
    function automatic logic [CFG_DATA_W-1:0] rand_side(input int hi);
        logic [CFG_DATA_W-1:0] v;
        int                    r;
        r = $urandom_range(0, 99);
        if (r < 6) v = '0;
        else if (r < 10) v = CFG_DATA_W'($urandom_range(SIDE_MAX + 1, 8191));
        else v = CFG_DATA_W'($urandom_range(1, hi));
        if ($urandom_range(0, 4) == 0)
            v[CFG_DATA_W-1:DIM_CFG_W] = (CFG_DATA_W-DIM_CFG_W)'($urandom_range(0, 7));
        return v;
    endfunction

    initial begin
        int                    rand_items;
        int                    pick;
        int                    n_items;
        int                    hi_side;
        logic [MODE_W-1:0]     m;
        logic [CFG_DATA_W-1:0] word;

        rand_items = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, restart mid-frame
        queue_bits(32'b010, 3);
        wait_drained();
        settings_done++;

        // unused mode, zero height and zero group size: three one-pixel groups, then idle
        write_reg(REG_ORDER_MODE, {14'h3FFF, ORDER_SPARE});
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, 16'd0);
        write_reg(REG_SCAN_GROUP_SIZE, 16'd0);
        queue_bits(32'b0000, 4);
        wait_drained();
        settings_done++;

        // single-point curve, idle after it, restart brings it back
        write_reg(REG_ORDER_MODE, {14'd0, ORDER_CURVE});
        write_reg(REG_FRAME_WIDTH, 16'd1);
        write_reg(REG_FRAME_HEIGHT, 16'd1);
        queue_bits(32'b100, 3);
        wait_drained();
        settings_done++;

        // 1x2 picture on a 2x2 curve: the last two points lie off the picture
        write_reg(REG_FRAME_HEIGHT, 16'd2);
        queue_bits(32'b00000, 5);
        wait_drained();
        settings_done++;

        // tile wider than the picture: empty frame
        write_reg(REG_ORDER_MODE, {14'd0, ORDER_TILE});
        write_reg(REG_FRAME_WIDTH, 16'd5);
        write_reg(REG_FRAME_HEIGHT, 16'd5);
        write_reg(REG_TILE_WIDTH, 16'd8);
        write_reg(REG_TILE_HEIGHT, 16'd1);
        queue_bits(32'b10, 2);
        wait_drained();
        settings_done++;

        // two 2x2 tiles side by side
        write_reg(REG_FRAME_WIDTH, 16'd4);
        write_reg(REG_FRAME_HEIGHT, 16'd2);
        write_reg(REG_TILE_WIDTH, 16'd2);
        write_reg(REG_TILE_HEIGHT, 16'd2);
        queue_bits(32'b0, 8);
        wait_drained();
        settings_done++;

        while (rand_items < 1500) begin
            if (rand_items < 500) begin
                send_idle_pct = 26;
                recv_idle_pct = 47;
            end else if (rand_items < 1000) begin
                send_idle_pct = 47;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(0, 9);
            if (pick < 3) m = ORDER_SCAN;
            else if (pick < 6) m = ORDER_CURVE;
            else if (pick < 9) m = ORDER_TILE;
            else m = ORDER_SPARE;
            word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
            word[MODE_W-1:0] = m;
            write_reg(REG_ORDER_MODE, word);
            if (m == ORDER_CURVE) begin
                hi_side = ($urandom_range(0, 3) == 0) ? 64 : 16;
                write_reg(REG_FRAME_WIDTH, rand_side(hi_side));
                write_reg(REG_FRAME_HEIGHT, rand_side(hi_side));
            end else if (m == ORDER_TILE) begin
                write_reg(REG_FRAME_WIDTH, rand_side(24));
                write_reg(REG_FRAME_HEIGHT, rand_side(16));
            end else begin
                write_reg(REG_FRAME_WIDTH, rand_side(16));
                write_reg(REG_FRAME_HEIGHT, rand_side(10));
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) word = '0;
            else if (pick < 14) word = '1;
            else word = CFG_DATA_W'($urandom_range(1, 40));
            write_reg(REG_SCAN_GROUP_SIZE, word);
            write_reg(REG_TILE_WIDTH, rand_side(8));
            write_reg(REG_TILE_HEIGHT, rand_side(6));
            n_items = $urandom_range(20, 160);
            queue_items(n_items, 4);
            rand_items += n_items;
            wait_drained();
            settings_done++;
        end

        // sizes clamped to the limit; long sink stall, then a sender pause
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_ORDER_MODE, {14'd0, ORDER_SCAN});
        write_reg(REG_FRAME_WIDTH, 16'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
        write_reg(REG_SCAN_GROUP_SIZE, 16'hFFFF);
        queue_items(150, 0);
        sink_stall_cycles = 300;
        wait_drained();
        queue_items(80, 3);
        wait_drained();
        settings_done++;

        repeat (PIPE_DEPTH + 5) @(negedge aclk);
        $display("Ran %0d items over %0d register settings: scanline, curve and tile walks,",
                 items_sent, settings_done);
        $display("with frame ends, restarts, clamped sizes and stalls; %0d results, %0d mismatches",
                 results_seen, errors);
        if (errors == 0 && visit_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", visit_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
